@@ design/rau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, command and status codes, and the control word of the
// iterative gcd / divide unit.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int RES_W    = 33;
   localparam int CMD_W    = 4;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_ADD      = 4'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_RED  = 4'd1;
   localparam logic [CMD_W-1:0] CMD_SUB      = 4'd2;
   localparam logic [CMD_W-1:0] CMD_SUB_RED  = 4'd3;
   localparam logic [CMD_W-1:0] CMD_MUL      = 4'd4;
   localparam logic [CMD_W-1:0] CMD_MUL_RED  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_DIV      = 4'd6;
   localparam logic [CMD_W-1:0] CMD_DIV_RED  = 4'd7;
   localparam logic [CMD_W-1:0] CMD_INVERSE  = 4'd8;
   localparam logic [CMD_W-1:0] CMD_NORMAL   = 4'd9;
   localparam logic [CMD_W-1:0] CMD_COMPARE  = 4'd10;

   localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STS_DIV_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] STS_ZERO_DEN = 2'd2;

   typedef struct packed {
      logic start;
      logic div_mode;
   } rau_iter_ctl_type;

endpackage

@@ design/rau_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module rau_mul #(
   parameter int OPW = 16
) (
   input  logic                  clock,
   input  logic signed [OPW-1:0] mul_a,
   input  logic signed [OPW-1:0] mul_b,
   output logic signed [2*OPW-1:0] product
);

   logic signed [2*OPW-1:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= mul_a * mul_b;
   end

   assign product = product_ff;

endmodule

@@ design/rau_iter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_iter
// Iterative gcd (binary, one step per cycle) and restoring divider (one
// quotient bit per cycle) sharing one subtractor. Result is held in u_ff.
// ----------------------------------------------------------------------------
module rau_iter #(
   parameter int WIDTH = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  rau_pkg::rau_iter_ctl_type  ctl,
   input  logic [WIDTH-1:0]           op_a,
   input  logic [WIDTH-1:0]           op_b,
   output logic                       done,
   output logic [WIDTH-1:0]           result
);
   import rau_pkg::*;

   localparam int CntW = $clog2(WIDTH + 1);

   logic             busy_ff, busy_in;
   logic             mode_ff, mode_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] u_ff, u_in;
   logic [WIDTH-1:0] v_ff, v_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [CntW-1:0]  k_ff, k_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;

   logic [WIDTH:0]   sub_a;
   logic [WIDTH:0]   sub_b;
   logic [WIDTH+1:0] diff;
   logic [WIDTH+1:0] diff_neg;
   logic             borrow;
   logic             u_zero;
   logic             v_zero;

   // shared subtractor
   always_comb begin
      sub_b    = {1'b0, v_ff};
      sub_a    = mode_ff ? {rem_ff, u_ff[WIDTH-1]} : {1'b0, u_ff};
      diff     = {1'b0, sub_a} - {1'b0, sub_b};
      diff_neg = '0 - diff;
      borrow   = diff[WIDTH+1];
      u_zero   = (u_ff == '0);
      v_zero   = (v_ff == '0);
   end

   always_comb begin
      busy_in = busy_ff;
      mode_in = mode_ff;
      done_in = 1'b0;
      u_in    = u_ff;
      v_in    = v_ff;
      rem_in  = rem_ff;
      k_in    = k_ff;
      cnt_in  = cnt_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         mode_in = ctl.div_mode;
         u_in    = op_a;
         v_in    = op_b;
         rem_in  = '0;
         k_in    = '0;
         cnt_in  = '0;
      end else if (busy_ff) begin
         if (!mode_ff) begin
            if (u_zero || v_zero) begin
               u_in    = (u_ff | v_ff) << k_ff;
               busy_in = 1'b0;
               done_in = 1'b1;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + CntW'(1);
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (!borrow) begin
               u_in = diff[WIDTH-1:0];
            end else begin
               v_in = diff_neg[WIDTH-1:0];
            end
         end else begin
            rem_in = borrow ? sub_a[WIDTH-1:0] : diff[WIDTH-1:0];
            u_in   = {u_ff[WIDTH-2:0], ~borrow};
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntW'(WIDTH - 1)) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      u_ff    <= u_in;
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      k_ff    <= k_in;
      cnt_ff  <= cnt_in;
   end

   assign done   = done_ff;
   assign result = u_ff;

endmodule

@@ design/rational_arithmetic_unit_top.sv @@
`timescale 1ns / 1ps
// Fraction arithmetic unit: one word in, one word out, one item at a time.
// Raw add, subtract, multiply, divide and compare pass a check state, three
// products through one registered multiplier, a form state and the load of
// the output register. Inverse skips the products; error and unused-command
// words go from the check straight to the output load. Reduced commands and
// normalize add a binary gcd on the (2*OPERAND_WIDTH+1)-bit magnitudes, one
// shift or subtract per cycle, and two restoring divisions by the gcd, of
// |num| and then of |den|, all through one shared subtractor. Input is
// stalled while an item is in flight; the next word is taken the cycle after
// the result is loaded. A finished result waits in the output register.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_top
// Add, subtract, multiply, divide, inverse, normalize and compare on signed
// fractions, with optional gcd reduction.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_top #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [rau_pkg::CMD_W-1:0]           req_command,
   input  logic signed [OPERAND_WIDTH-1:0]     req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0]     req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]     req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0]     req_b_den,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [rau_pkg::RES_W-1:0]    rsp_res_num,
   output logic signed [rau_pkg::RES_W-1:0]    rsp_res_den,
   output logic                                rsp_less_or_equal,
   output logic [rau_pkg::STATUS_W-1:0]        rsp_status
);
   import rau_pkg::*;

   localparam int OpW   = OPERAND_WIDTH;
   localparam int ProdW = 2 * OpW;
   localparam int SumW  = ProdW + 1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_FORM,
      ST_REDUCE,
      ST_GCD_WAIT,
      ST_DIVN_WAIT,
      ST_DIVD_WAIT,
      ST_DONE
   } state_type;

   state_type                 state_ff;
   logic [CMD_W-1:0]          cmd_ff;
   logic signed [OpW-1:0]     a_num_ff;
   logic signed [OpW-1:0]     a_den_ff;
   logic signed [OpW-1:0]     b_num_ff;
   logic signed [OpW-1:0]     b_den_ff;
   logic [1:0]                mul_idx_ff;
   logic signed [ProdW-1:0]   p0_ff;
   logic signed [ProdW-1:0]   p1_ff;
   logic signed [ProdW-1:0]   p2_ff;
   logic signed [SumW-1:0]    fin_num_ff;
   logic signed [SumW-1:0]    fin_den_ff;
   logic                      fin_le_ff;
   logic [STATUS_W-1:0]       fin_status_ff;
   logic [SumW-1:0]           g_ff;
   logic                      rsp_valid_ff;
   logic signed [RES_W-1:0]   rsp_res_num_ff;
   logic signed [RES_W-1:0]   rsp_res_den_ff;
   logic                      rsp_le_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;

   logic                      is_mul;
   logic                      is_div;
   logic                      uses_b;
   logic                      cmd_bad;
   logic                      zero_den;
   logic                      zero_div;
   logic                      do_reduce;
   logic                      skip_mul;
   logic signed [OpW-1:0]     mul_a;
   logic signed [OpW-1:0]     mul_b;
   logic signed [ProdW-1:0]   mul_p;
   logic signed [SumW-1:0]    form_num;
   logic signed [SumW-1:0]    form_den;
   logic                      cmp_le;
   logic [SumW-1:0]           num_mag;
   logic [SumW-1:0]           den_mag;
   logic [SumW-1:0]           quot_neg;
   rau_iter_ctl_type          iter_ctl;
   logic [SumW-1:0]           iter_a;
   logic [SumW-1:0]           iter_b;
   logic                      iter_done;
   logic [SumW-1:0]           iter_result;

   // command decode and operand checks
   always_comb begin
      is_mul    = (cmd_ff == CMD_MUL) || (cmd_ff == CMD_MUL_RED);
      is_div    = (cmd_ff == CMD_DIV) || (cmd_ff == CMD_DIV_RED);
      uses_b    = (cmd_ff != CMD_INVERSE) && (cmd_ff != CMD_NORMAL);
      skip_mul  = !uses_b;
      cmd_bad   = (cmd_ff > CMD_COMPARE);
      zero_den  = (a_den_ff == '0) || (uses_b && (b_den_ff == '0));
      zero_div  = (is_div && (b_num_ff == '0)) ||
                  ((cmd_ff == CMD_INVERSE) && (a_num_ff == '0));
      do_reduce = (cmd_ff == CMD_ADD_RED) || (cmd_ff == CMD_SUB_RED) ||
                  (cmd_ff == CMD_MUL_RED) || (cmd_ff == CMD_DIV_RED) ||
                  (cmd_ff == CMD_NORMAL);
   end

   // multiplier operand schedule
   always_comb begin
      case (mul_idx_ff)
         2'd0: begin
            mul_a = a_num_ff;
            mul_b = is_mul ? b_num_ff : b_den_ff;
         end
         2'd1: begin
            mul_a = b_num_ff;
            mul_b = a_den_ff;
         end
         default: begin
            mul_a = a_den_ff;
            mul_b = is_div ? b_num_ff : b_den_ff;
         end
      endcase
   end

   rau_mul #(
      .OPW (OpW)
   ) u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (mul_p)
   );

   always_comb begin
      case (cmd_ff)
         CMD_ADD, CMD_ADD_RED: form_num = SumW'(p0_ff) + SumW'(p1_ff);
         CMD_SUB, CMD_SUB_RED: form_num = SumW'(p0_ff) - SumW'(p1_ff);
         CMD_INVERSE:          form_num = SumW'(a_den_ff);
         CMD_NORMAL:           form_num = SumW'(a_num_ff);
         default:              form_num = SumW'(p0_ff);
      endcase
      case (cmd_ff)
         CMD_INVERSE: form_den = SumW'(a_num_ff);
         CMD_NORMAL:  form_den = SumW'(a_den_ff);
         default:     form_den = SumW'(p2_ff);
      endcase
      if (a_den_ff[OpW-1] == b_den_ff[OpW-1]) begin
         cmp_le = (p0_ff <= p1_ff);
      end else begin
         cmp_le = (p0_ff >= p1_ff);
      end
   end

   always_comb begin
      num_mag  = fin_num_ff[SumW-1] ? (~fin_num_ff + SumW'(1)) : fin_num_ff;
      den_mag  = fin_den_ff[SumW-1] ? (~fin_den_ff + SumW'(1)) : fin_den_ff;
      quot_neg = '0 - iter_result;
   end

   // gcd, then |num|/g, then |den|/g
   always_comb begin
      iter_ctl.start    = (state_ff == ST_REDUCE) ||
                          (iter_done && ((state_ff == ST_GCD_WAIT) ||
                                         (state_ff == ST_DIVN_WAIT)));
      iter_ctl.div_mode = (state_ff != ST_REDUCE);
      case (state_ff)
         ST_REDUCE: begin
            iter_a = num_mag;
            iter_b = den_mag;
         end
         ST_GCD_WAIT: begin
            iter_a = num_mag;
            iter_b = iter_result;
         end
         default: begin
            iter_a = den_mag;
            iter_b = g_ff;
         end
      endcase
   end

   rau_iter #(
      .WIDTH (SumW)
   ) u_iter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (iter_ctl),
      .op_a   (iter_a),
      .op_b   (iter_b),
      .done   (iter_done),
      .result (iter_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mul_idx_ff   <= 2'd0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  cmd_ff   <= req_command;
                  a_num_ff <= req_a_num;
                  a_den_ff <= req_a_den;
                  b_num_ff <= req_b_num;
                  b_den_ff <= req_b_den;
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               fin_num_ff    <= '0;
               fin_den_ff    <= '0;
               fin_le_ff     <= 1'b0;
               fin_status_ff <= STS_OK;
               mul_idx_ff    <= 2'd0;
               if (cmd_bad) begin
                  state_ff <= ST_DONE;
               end else if (zero_den) begin
                  fin_status_ff <= STS_ZERO_DEN;
                  state_ff      <= ST_DONE;
               end else if (zero_div) begin
                  fin_status_ff <= STS_DIV_ZERO;
                  state_ff      <= ST_DONE;
               end else if (skip_mul) begin
                  state_ff <= ST_FORM;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               case (mul_idx_ff)
                  2'd1:    p0_ff <= mul_p;
                  2'd2:    p1_ff <= mul_p;
                  2'd3:    p2_ff <= mul_p;
                  default: ;
               endcase
               mul_idx_ff <= mul_idx_ff + 2'd1;
               if (mul_idx_ff == 2'd3) begin
                  state_ff <= ST_FORM;
               end
            end
            ST_FORM: begin
               if (cmd_ff == CMD_COMPARE) begin
                  fin_le_ff <= cmp_le;
                  state_ff  <= ST_DONE;
               end else begin
                  fin_num_ff <= form_num;
                  fin_den_ff <= form_den;
                  state_ff   <= do_reduce ? ST_REDUCE : ST_DONE;
               end
            end
            ST_REDUCE: begin
               state_ff <= ST_GCD_WAIT;
            end
            ST_GCD_WAIT: begin
               if (iter_done) begin
                  g_ff     <= iter_result;
                  state_ff <= ST_DIVN_WAIT;
               end
            end
            ST_DIVN_WAIT: begin
               if (iter_done) begin
                  fin_num_ff <= fin_num_ff[SumW-1] ? quot_neg : iter_result;
                  state_ff   <= ST_DIVD_WAIT;
               end
            end
            ST_DIVD_WAIT: begin
               if (iter_done) begin
                  fin_den_ff <= fin_den_ff[SumW-1] ? quot_neg : iter_result;
                  state_ff   <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_res_num_ff <= RES_W'(fin_num_ff);
                  rsp_res_den_ff <= RES_W'(fin_den_ff);
                  rsp_le_ff      <= fin_le_ff;
                  rsp_status_ff  <= fin_status_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_res_num       = rsp_res_num_ff;
   assign rsp_res_den       = rsp_res_den_ff;
   assign rsp_less_or_equal = rsp_le_ff;
   assign rsp_status        = rsp_status_ff;

   // error words carry no fraction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STS_OK)) |->
         ((rsp_res_num == '0) && (rsp_res_den == '0) && !rsp_less_or_equal))
      else $error("error word carries data");

   // a true compare flag only on an ok word with no fraction
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_less_or_equal) |->
         ((rsp_status == STS_OK) && (rsp_res_den == '0)))
      else $error("compare flag on non-compare word");

   // the iterative unit finishes only when the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      iter_done |-> ((state_ff == ST_GCD_WAIT) || (state_ff == ST_DIVN_WAIT) ||
                     (state_ff == ST_DIVD_WAIT)))
      else $error("unexpected iterative unit done");

   // denominator is never zero, so the gcd is never zero
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_GCD_WAIT) && iter_done) |-> (iter_result != '0))
      else $error("zero gcd");

   // an accepted word blocks the input until it is finished
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && (state_ff == ST_CHECK)))
      else $error("input not blocked after accept");

endmodule
